[rtl/core/assert_macros.svh]
// Assertion shorthands for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define AST_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication.
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

[rtl/core/hsl_adj_pkg.sv]
// ----------------------------------------------------------------------------
// hsl_adj_pkg
// Shared types and helpers of the HSL hue/saturation/lightness adjuster.
// ----------------------------------------------------------------------------
package hsl_adj_pkg;

  typedef struct packed {
    logic [7:0] in_alpha;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] mask_weight;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_alpha;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } pix_out_t;

  // configuration register indexes
  localparam logic [1:0] REG_HUE   = 2'd0;
  localparam logic [1:0] REG_SAT   = 2'd1;
  localparam logic [1:0] REG_LIGHT = 2'd2;

  localparam logic [10:0] WHEEL = 11'd1536;

  // piece of the hue ramp a channel falls on
  typedef enum logic [1:0] {
    RAMP_RISE,
    RAMP_HOLD_Q,
    RAMP_FALL,
    RAMP_HOLD_P
  } ramp_mode_t;

  // partial remainder and quotient of the restoring dividers
  typedef struct packed {
    logic [15:0] rem;
    logic [8:0]  quo;
  } div_t;

  // trunc(clamp(deg, -180, 180) * 1536 / 360) = trunc(deg * 64 / 15)
  function automatic logic signed [10:0] hue_shift(input logic signed [8:0] deg);
    logic [7:0]  mag;
    logic [13:0] x;
    logic [26:0] prod;
    logic [9:0]  q;
    logic [13:0] rem;
    logic        neg;
    neg = deg[8];
    if (deg > 9'sd180) begin
      mag = 8'd180;
    end else if (deg < -9'sd180) begin
      mag = 8'd180;
    end else if (neg) begin
      mag = 8'(-deg);
    end else begin
      mag = deg[7:0];
    end
    x    = {mag, 6'b0};
    prod = 27'(x) * 27'd4369;  // 2^16/15, rounded down
    q    = prod[25:16];
    rem  = x - (14'(q) * 14'd15);
    if (rem >= 14'd15) begin
      q = q + 10'd1;
    end
    return neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  // floor(x / 255) for x below 130815 (513 * 255)
  function automatic logic [8:0] div255(input logic [16:0] x);
    logic [8:0] q;
    logic [9:0] r;
    q = x[16:8];
    r = 10'(x[7:0]) + 10'(x[16:8]);
    if (r >= 10'd255) begin
      r = r - 10'd255;
      q = q + 9'd1;
    end
    if (r >= 10'd255) begin
      q = q + 9'd1;
    end
    return q;
  endfunction

  // three quotient bits of a restoring division, top bit first
  function automatic div_t div3(input div_t cur, input logic [8:0] den,
                                input int top);
    div_t       nxt;
    logic [24:0] cmp;
    nxt = cur;
    for (int i = 0; i < 3; i++) begin
      cmp = 25'(den) << (top - i);
      if (25'(nxt.rem) >= cmp) begin
        nxt.rem = nxt.rem - cmp[15:0];
        nxt.quo[top - i] = 1'b1;
      end
    end
    return nxt;
  endfunction

endpackage

[rtl/core/hsl_hue_saturation_adjust_top.sv]
// ----------------------------------------------------------------------------
// hsl_hue_saturation_adjust_top
// Per-pixel HSL hue rotation, saturation/lightness offset and masked blend.
// ----------------------------------------------------------------------------
// Usage:
//  - Source channel src_valid/src_stall/src_data carries one ARGB pixel plus
//    a mask weight per request; dst_valid/dst_stall/dst_data returns one
//    adjusted ARGB pixel per request, in order.
//  - Config: cfg_we/cfg_index/cfg_data writes hue shift (deg), saturation
//    delta and lightness delta. Write only while the pipe is empty. The hue
//    shift is turned into wheel units once, at write time.
//  - Throughput: one pixel per cycle while no held output freezes the pipe;
//    the 9-bit quotients for hue and saturation come out of restoring
//    dividers unrolled at three bits per stage.
//  - Pipe: prep, divide x3, HSL adjust, lightness multiply, q/p and ramp
//    select, ramp multiply, channel select, blend multiply, blend divide.
//  - dst_stall with a pixel waiting freezes the whole pipe; src_stall then
//    rises in the same cycle, so nothing is dropped or repeated.
//  - Reset (synchronous, rst high) empties the pipe and zeroes all three
//    config registers; weight 0 passes the pixel through, alpha always does.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsl_hue_saturation_adjust_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [8:0]            cfg_data,
  input  logic                  src_valid,
  output logic                  src_stall,
  input  hsl_adj_pkg::pix_in_t  src_data,
  output logic                  dst_valid,
  input  logic                  dst_stall,
  output hsl_adj_pkg::pix_out_t dst_data
);
  import hsl_adj_pkg::*;

  localparam int NSTG = 10;

  // config
  logic signed [10:0] shift;
  logic signed [8:0]  sat_delta;
  logic signed [8:0]  light_delta;

  // pipe control
  logic            adv;
  logic [NSTG:1]   vld;

  // source pixel rides along every stage
  pix_in_t  pix [NSTG:1];

  // stage 1..4: prep and division
  logic             chroma [4:1];
  logic [7:0]       lum    [4:1];
  logic             hneg   [4:1];
  logic [10:0]      hbase  [4:1];
  logic [8:0]       sden   [4:1];
  logic [8:0]       hden   [4:1];
  div_t             sdiv   [4:1];
  div_t             hdiv   [4:1];

  // stage 5..
  logic [10:0]      hue5;
  logic [7:0]       sat5, lit5;
  logic [16:0]      prod6;
  logic             low6;
  logic [10:0]      hue6;
  logic [7:0]       sat6, lit6;
  logic [8:0]       q7, p7;
  logic [7:0]       lit7, lit8;
  logic             gray7, gray8;
  ramp_mode_t       mode7 [3];
  ramp_mode_t       mode8 [3];
  logic [8:0]       frac7 [3];
  logic [17:0]      rprod8 [3];
  logic [8:0]       q8, p8;
  logic [7:0]       newc9 [3];
  logic [15:0]      bprod10 [3];
  logic             bneg10  [3];

  // --------------------------------------------------------------------------
  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      shift       <= '0;
      sat_delta   <= '0;
      light_delta <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HUE:   shift       <= hue_shift($signed(cfg_data));
        REG_SAT:   sat_delta   <= $signed(cfg_data);
        REG_LIGHT: light_delta <= $signed(cfg_data);
        default:   ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // flow: the whole pipe moves unless a finished pixel is held at the output
  assign adv       = !(dst_valid && dst_stall);
  assign src_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      dst_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[NSTG-1:1], src_valid};
      dst_valid <= vld[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix[1] <= src_data;
      for (int i = 2; i <= NSTG; i++) begin
        pix[i] <= pix[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: max/min, lightness, dividend and divisor setup
  logic [7:0]  c_r, c_g, c_b, c_hi, c_lo, c_d, c_a, c_b2, c_mag;
  logic [8:0]  c_sum, c_sden;
  logic [10:0] c_base;
  logic        c_neg;

  always_comb begin
    c_r  = src_data.in_red;
    c_g  = src_data.in_green;
    c_b  = src_data.in_blue;
    c_hi = (c_r > c_g) ? ((c_r > c_b) ? c_r : c_b) : ((c_g > c_b) ? c_g : c_b);
    c_lo = (c_r < c_g) ? ((c_r < c_b) ? c_r : c_b) : ((c_g < c_b) ? c_g : c_b);
    c_sum = 9'(c_hi) + 9'(c_lo);
    c_d   = c_hi - c_lo;
    c_sden = (c_sum[8:1] > 8'd127) ? (9'd510 - c_sum) : c_sum;
    // hue sextant pair chosen by which channel is the max
    if (c_hi == c_r) begin
      c_a = c_g; c_b2 = c_b; c_base = 11'd0;
    end else if (c_hi == c_g) begin
      c_a = c_b; c_b2 = c_r; c_base = 11'd512;
    end else begin
      c_a = c_r; c_b2 = c_g; c_base = 11'd1024;
    end
    c_neg = c_a < c_b2;
    c_mag = c_neg ? (c_b2 - c_a) : (c_a - c_b2);
  end

  // stage 1 setup, then stages 2..4 at three quotient bits each
  always_ff @(posedge clk) begin
    if (adv) begin
      chroma[1]   <= (c_d != 8'd0);
      lum[1]      <= c_sum[8:1];
      hneg[1]     <= c_neg;
      hbase[1]    <= c_base;
      sden[1]     <= (c_d == 8'd0) ? 9'd1 : c_sden;
      hden[1]     <= (c_d == 8'd0) ? 9'd1 : 9'(c_d);
      sdiv[1].rem <= 16'(c_d) * 16'd255;
      sdiv[1].quo <= '0;
      hdiv[1].rem <= {c_mag, 8'b0};
      hdiv[1].quo <= '0;
      for (int s = 2; s <= 4; s++) begin
        chroma[s] <= chroma[s-1];
        lum[s]    <= lum[s-1];
        hneg[s]   <= hneg[s-1];
        hbase[s]  <= hbase[s-1];
        sden[s]   <= sden[s-1];
        hden[s]   <= hden[s-1];
        sdiv[s]   <= div3(sdiv[s-1], sden[s-1], 14 - 3 * s);
        hdiv[s]   <= div3(hdiv[s-1], hden[s-1], 14 - 3 * s);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: finish hue, rotate, offset saturation and lightness
  logic signed [11:0] h0;
  logic signed [12:0] h1;
  logic signed [10:0] s_sum, l_sum;
  logic [7:0]         s_raw;

  always_comb begin
    h0 = $signed({1'b0, hbase[4]}) + (hneg[4] ? -$signed({3'b0, hdiv[4].quo})
                                                : $signed({3'b0, hdiv[4].quo}));
    if (h0 < 0) begin
      h0 = h0 + 12'sd1536;
    end
    if (!chroma[4]) begin
      h0 = '0;
    end
    h1 = 13'(h0) + 13'(shift);
    if (h1 < 0) begin
      h1 = h1 + 13'sd1536;
    end else if (h1 >= 13'sd1536) begin
      h1 = h1 - 13'sd1536;
    end
    s_raw = chroma[4] ? sdiv[4].quo[7:0] : 8'd0;
    s_sum = $signed({3'b0, s_raw}) + 11'(sat_delta);
    l_sum = $signed({3'b0, lum[4]}) + 11'(light_delta);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hue5 <= h1[10:0];
      sat5 <= (s_sum < 0) ? 8'd0 : ((s_sum > 11'sd255) ? 8'd255 : s_sum[7:0]);
      lit5 <= (l_sum < 0) ? 8'd0 : ((l_sum > 11'sd255) ? 8'd255 : l_sum[7:0]);
    end
  end

  // stage 6: lightness product for q
  always_ff @(posedge clk) begin
    if (adv) begin
      low6  <= lit5 < 8'd128;
      prod6 <= (lit5 < 8'd128) ? 17'(lit5) * (17'(sat5) + 17'd255)
                               : 17'(lit5) * 17'(sat5);
      hue6  <= hue5;
      sat6  <= sat5;
      lit6  <= lit5;
    end
  end

  // stage 7: q, p and per-channel ramp position
  logic [8:0]  c_qd, c_q;
  logic [10:0] c_t [3];

  always_comb begin
    c_qd = div255(prod6);
    c_q  = low6 ? c_qd : (9'(lit6) + 9'(sat6) - c_qd);
    c_t[0] = (hue6 >= 11'd1024) ? (hue6 - 11'd1024) : (hue6 + 11'd512);
    c_t[1] = hue6;
    c_t[2] = (hue6 >= 11'd512) ? (hue6 - 11'd512) : (hue6 + 11'd1024);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q7    <= c_q;
      p7    <= {lit6, 1'b0} - c_q;
      lit7  <= lit6;
      gray7 <= (sat6 == 8'd0);
      for (int c = 0; c < 3; c++) begin
        if (c_t[c] < 11'd256) begin
          mode7[c] <= RAMP_RISE;
          frac7[c] <= c_t[c][8:0];
        end else if (c_t[c] < 11'd768) begin
          mode7[c] <= RAMP_HOLD_Q;
          frac7[c] <= '0;
        end else if (c_t[c] < 11'd1024) begin
          mode7[c] <= RAMP_FALL;
          frac7[c] <= 9'(11'd1024 - c_t[c]);
        end else begin
          mode7[c] <= RAMP_HOLD_P;
          frac7[c] <= '0;
        end
      end
    end
  end

  // stage 8: ramp products (q >= p, so the shift truncates correctly)
  always_ff @(posedge clk) begin
    if (adv) begin
      q8    <= q7;
      p8    <= p7;
      lit8  <= lit7;
      gray8 <= gray7;
      for (int c = 0; c < 3; c++) begin
        mode8[c]  <= mode7[c];
        rprod8[c] <= 18'(q7 - p7) * 18'(frac7[c]);
      end
    end
  end

  // stage 9: adjusted channel
  logic [9:0] c_val [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      case (mode8[c])
        RAMP_RISE, RAMP_FALL: c_val[c] = 10'(p8) + rprod8[c][17:8];
        RAMP_HOLD_Q:          c_val[c] = 10'(q8);
        RAMP_HOLD_P:          c_val[c] = 10'(p8);
        default:              c_val[c] = 10'(p8);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        newc9[c] <= gray8 ? lit8 : ((c_val[c] > 10'd255) ? 8'd255 : c_val[c][7:0]);
      end
    end
  end

  // stage 10: blend magnitude times weight
  logic [7:0] o9 [3];
  logic [7:0] o10 [3];

  always_comb begin
    o9[0]  = pix[9].in_red;
    o9[1]  = pix[9].in_green;
    o9[2]  = pix[9].in_blue;
    o10[0] = pix[10].in_red;
    o10[1] = pix[10].in_green;
    o10[2] = pix[10].in_blue;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        bneg10[c]  <= newc9[c] < o9[c];
        bprod10[c] <= 16'((newc9[c] < o9[c]) ? (o9[c] - newc9[c])
                                             : (newc9[c] - o9[c]))
                      * 16'(pix[9].mask_weight);
      end
    end
  end

  // output: divide by 255, apply sign, register
  logic [8:0] c_bq9 [3];
  logic [7:0] c_bq [3];
  logic [7:0] c_out [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      c_bq9[c] = div255(17'(bprod10[c]));
      c_bq[c]  = c_bq9[c][7:0];
      c_out[c] = bneg10[c] ? (o10[c] - c_bq[c]) : (o10[c] + c_bq[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dst_data.out_alpha <= pix[10].in_alpha;
      dst_data.out_red   <= c_out[0];
      dst_data.out_green <= c_out[1];
      dst_data.out_blue  <= c_out[2];
    end
  end

  // --------------------------------------------------------------------------
  // checks
  // zero-weight pixel leaving the last stage: colors come out as they went in
  logic pass10;
  assign pass10 = vld[10] && adv && (pix[10].mask_weight == 8'd0);

  `AST_IMPLY(a_q_ge_p, vld[7], q7 >= p7)
  `AST_NEXT(a_frozen, !adv, $stable(vld))
  `AST_NEXT(a_zero_weight, pass10, dst_data[23:0] == $past(pix[10][31:8]))

endmodule
